@@ rtl/cbms_pkg.sv @@
`default_nettype none
package cbms_pkg;

	localparam int NUM_CLASSES_DEF = 16;
	localparam int NUM_BANDS_DEF   = 8;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int CMD_W  = 2;
	localparam int CLS_W  = 4;
	localparam int BAND_W = 3;
	localparam int SMP_W  = 16;
	localparam int STAT_W = 2;
	localparam int FIX_W  = 24;

	localparam int CNT_W = 24;
	localparam int SUM_W = 40;
	localparam int SQS_W = 56;

	// shared unit widths
	localparam int ACC_W  = 80;
	localparam int SHF_W  = 96;
	localparam int QUO_W  = 64;
	localparam int DVS_W  = 48;
	localparam int STEP_W = 7;

	localparam logic [STEP_W-1:0] STEPS_MEAN = 7'd48;
	localparam logic [STEP_W-1:0] STEPS_MULQ = 7'd24;
	localparam logic [STEP_W-1:0] STEPS_MULS = 7'd40;
	localparam logic [STEP_W-1:0] STEPS_VDIV = 7'd96;
	localparam logic [STEP_W-1:0] STEPS_SQRT = 7'd32;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_QUERY = 2'd2
	} cmd_e;

	localparam logic [STAT_W-1:0] STAT_VALID  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NODATA = 2'd1;
	localparam logic [STAT_W-1:0] STAT_SINGLE = 2'd2;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic [SUM_W-1:0] sum;
		logic [SQS_W-1:0] sqs;
	} acc_t;

	typedef enum logic [1:0] {
		ALU_MUL  = 2'd0,
		ALU_DIV  = 2'd1,
		ALU_SQRT = 2'd2
	} alu_mode_e;

	typedef struct packed {
		logic              start;
		alu_mode_e         mode;
		logic              sub;
		logic              clr;
		logic [STEP_W-1:0] steps;
	} alu_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD,
		ST_QRD,
		ST_MEAN,
		ST_MULQ,
		ST_MULS,
		ST_VDIV,
		ST_SQRT,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

@@ rtl/cbms_if.sv @@
`default_nettype none
interface cbms_req_if import cbms_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [CLS_W-1:0]  class_index;
	logic [BAND_W-1:0] band_index;
	logic [SMP_W-1:0]  sample_value;

	modport source (output valid, command, class_index, band_index, sample_value,
		input ready);
	modport sink (input valid, command, class_index, band_index, sample_value,
		output ready);
endinterface

interface cbms_rsp_if import cbms_pkg::*;;
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [FIX_W-1:0]  mean_value;
	logic [FIX_W-1:0]  stdev_value;
	logic [CNT_W-1:0]  pixel_count;

	modport source (output valid, status, mean_value, stdev_value, pixel_count,
		input ready);
	modport sink (input valid, status, mean_value, stdev_value, pixel_count,
		output ready);
endinterface
`default_nettype wire

@@ rtl/cbms_store.sv @@
`default_nettype none
module cbms_store import cbms_pkg::*; #(
	parameter int DEPTH = NUM_CLASSES_DEF * NUM_BANDS_DEF,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             clr,
	input  wire logic             rd_en,
	input  wire logic [IDX_W-1:0] rd_addr,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_addr,
	input  wire acc_t             wr_data,
	output acc_t                  rd_data
);

	acc_t mem [DEPTH];
	acc_t rd_q;
	logic [DEPTH-1:0] vld_q;
	logic rvld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// entry not yet written since the last clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (clr) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rvld_q ? rd_q : '0;

endmodule
`default_nettype wire

@@ rtl/cbms_alu.sv @@
`default_nettype none
module cbms_alu import cbms_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire alu_req_t         req,
	input  wire logic [SHF_W-1:0] opa,
	input  wire logic [QUO_W-1:0] opb,
	input  wire logic [DVS_W-1:0] dvs,
	output logic                  done,
	output logic [ACC_W-1:0]      acc,
	output logic [QUO_W-1:0]      quo
);

	logic              busy_q, done_q, sub_q;
	alu_mode_e         mode_q;
	logic [STEP_W-1:0] cnt_q;
	logic [ACC_W-1:0]  acc_q;
	logic [SHF_W-1:0]  shf_q;
	logic [QUO_W-1:0]  quo_q;
	logic [DVS_W-1:0]  dvs_q;

	logic [ACC_W-1:0] t_div, t_sqr, opx, opy;
	logic             sub;
	logic [ACC_W:0]   sum;
	logic             cy;

	assign t_div = {acc_q[ACC_W-2:0], shf_q[SHF_W-1]};
	assign t_sqr = {acc_q[ACC_W-3:0], shf_q[SHF_W-1 -: 2]};

	// the one adder: accumulate, trial subtract for divide and root
	always_comb begin
		case (mode_q)
			ALU_MUL: begin
				opx = acc_q;
				opy = shf_q[ACC_W-1:0];
				sub = sub_q;
			end
			ALU_DIV: begin
				opx = t_div;
				opy = {{(ACC_W-DVS_W){1'b0}}, dvs_q};
				sub = 1'b1;
			end
			default: begin
				opx = t_sqr;
				opy = {{(ACC_W-QUO_W-2){1'b0}}, quo_q, 2'b01};
				sub = 1'b1;
			end
		endcase
		sum = {1'b0, opx} + {1'b0, (sub ? ~opy : opy)} + {{ACC_W{1'b0}}, sub};
		cy  = sum[ACC_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == STEP_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mode_q <= req.mode;
			sub_q  <= req.sub;
			cnt_q  <= req.steps;
			dvs_q  <= dvs;
			quo_q  <= opb;
			shf_q  <= opa;
			if (req.clr) begin
				acc_q <= '0;
			end
		end else if (busy_q) begin
			cnt_q <= cnt_q - STEP_W'(1);
			case (mode_q)
				ALU_MUL: begin
					if (quo_q[0]) begin
						acc_q <= sum[ACC_W-1:0];
					end
					shf_q <= shf_q << 1;
					quo_q <= quo_q >> 1;
				end
				ALU_DIV: begin
					acc_q <= cy ? sum[ACC_W-1:0] : t_div;
					quo_q <= {quo_q[QUO_W-2:0], cy};
					shf_q <= shf_q << 1;
				end
				default: begin
					acc_q <= cy ? sum[ACC_W-1:0] : t_sqr;
					quo_q <= {quo_q[QUO_W-2:0], cy};
					shf_q <= shf_q << 2;
				end
			endcase
		end
	end

	assign done = done_q;
	assign acc  = acc_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

@@ rtl/class_band_mean_stdev_accumulator_top.sv @@
`default_nettype none
// Add: store read, then write back; ready again after that.
// Clear: all pairs read as empty at once through per-entry valid bits.
// Query: on the shared add/subtract unit, 48 divide steps for the mean, then
// 24 + 40 shift-add steps for n*Q - S*S, 96 divide steps and 32 root steps
// (only mean when n is 1, none when empty). One word is worked on at a time.
// Reset (arst_n low, asynchronous): sequencer idle, all accumulators empty.
module class_band_mean_stdev_accumulator_top import cbms_pkg::*; #(
	parameter int NUM_CLASSES = NUM_CLASSES_DEF,
	parameter int NUM_BANDS   = NUM_BANDS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	cbms_req_if.sink  req,
	cbms_rsp_if.source rsp
);

	localparam int PAIRS = NUM_CLASSES * NUM_BANDS;
	localparam int IDX_W = $clog2(PAIRS);
	localparam logic [SMP_W-1:0] VMAX = SMP_W'((1 << SAMPLE_BITS) - 1);
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	state_t state_q, state_d;

	// word held while it is worked on
	logic [IDX_W-1:0]   idx_q;
	logic               rng_q;
	logic [SMP_W-1:0]   val_q;
	logic [2*SMP_W-1:0] sq_q;
	logic [CNT_W-1:0]   n_q;
	logic [SUM_W-1:0]   s_q;
	logic [SQS_W-1:0]   q_q;
	logic [DVS_W-1:0]   dd_q;
	logic [FIX_W-1:0]   mean_q, sd_q;
	logic [STAT_W-1:0]  stat_q;

	// result register, parts the sequencer from the sink
	logic               ov_q;
	logic [STAT_W-1:0]  o_stat_q;
	logic [FIX_W-1:0]   o_mean_q, o_sd_q;
	logic [CNT_W-1:0]   o_cnt_q;

	logic             accept, in_rng, load;
	logic [IDX_W-1:0] idx;
	logic [SMP_W-1:0] vsat;

	acc_t rd_data, wr_data;
	logic wr_en, rd_en, clr;
	logic [CNT_W-1:0] rn;
	logic [SUM_W-1:0] rs;
	logic [SQS_W-1:0] rq;

	alu_req_t         alu_req;
	logic [SHF_W-1:0] alu_a;
	logic [QUO_W-1:0] alu_b;
	logic [DVS_W-1:0] alu_d;
	logic             alu_done;
	logic [ACC_W-1:0] alu_acc;
	logic [QUO_W-1:0] alu_quo;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign in_rng    = (32'(req.class_index) < NUM_CLASSES) &&
		(32'(req.band_index) < NUM_BANDS);
	assign idx  = IDX_W'(32'(req.class_index) * NUM_BANDS + 32'(req.band_index));
	assign vsat = (req.sample_value > VMAX) ? VMAX : req.sample_value;

	// out-of-range query answers as an empty pair
	assign rn = rng_q ? rd_data.cnt : '0;
	assign rs = rng_q ? rd_data.sum : '0;
	assign rq = rng_q ? rd_data.sqs : '0;

	assign clr   = accept && (req.command == CMD_CLEAR);
	assign rd_en = accept && (req.command == CMD_ADD || req.command == CMD_QUERY);
	assign wr_en = (state_q == ST_ADD) && (rd_data.cnt != CNT_MAX);
	assign wr_data.cnt = rd_data.cnt + CNT_W'(1);
	assign wr_data.sum = rd_data.sum + SUM_W'(val_q);
	assign wr_data.sqs = rd_data.sqs + SQS_W'(sq_q);

	assign load = (state_q == ST_OUT) && (!ov_q || rsp.ready);

	cbms_store #(
		.DEPTH(PAIRS),
		.IDX_W(IDX_W)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (clr),
		.rd_en  (rd_en),
		.rd_addr(idx),
		.wr_en  (wr_en),
		.wr_addr(idx_q),
		.wr_data(wr_data),
		.rd_data(rd_data)
	);

	cbms_alu u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (alu_req),
		.opa   (alu_a),
		.opb   (alu_b),
		.dvs   (alu_d),
		.done  (alu_done),
		.acc   (alu_acc),
		.quo   (alu_quo)
	);

	// sequencer: next state and the start of each pass of the shared unit
	always_comb begin
		state_d       = state_q;
		alu_req.start = 1'b0;
		alu_req.mode  = ALU_DIV;
		alu_req.sub   = 1'b0;
		alu_req.clr   = 1'b1;
		alu_req.steps = STEPS_MEAN;
		alu_a         = '0;
		alu_b         = '0;
		alu_d         = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd_e'(req.command))
						CMD_ADD:   state_d = in_rng ? ST_ADD : ST_IDLE;
						CMD_QUERY: state_d = ST_QRD;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD: begin
				state_d = ST_IDLE;
			end
			ST_QRD: begin
				// mean: (S << 8) / n, dividend placed at the top of the shifter
				if (rn == '0) begin
					state_d = ST_OUT;
				end else begin
					alu_req.start = 1'b1;
					alu_a   = {rs, 8'b0, {(SHF_W-SUM_W-8){1'b0}}};
					alu_d   = DVS_W'(rn);
					state_d = ST_MEAN;
				end
			end
			ST_MEAN: begin
				if (alu_done) begin
					if (n_q == CNT_W'(1)) begin
						state_d = ST_OUT;
					end else begin
						alu_req.start = 1'b1;
						alu_req.mode  = ALU_MUL;
						alu_req.steps = STEPS_MULQ;
						alu_a   = SHF_W'(q_q);
						alu_b   = QUO_W'(n_q);
						state_d = ST_MULQ;
					end
				end
			end
			ST_MULQ: begin
				// subtract S*S from the n*Q left in the accumulator
				if (alu_done) begin
					alu_req.start = 1'b1;
					alu_req.mode  = ALU_MUL;
					alu_req.sub   = 1'b1;
					alu_req.clr   = 1'b0;
					alu_req.steps = STEPS_MULS;
					alu_a   = SHF_W'(s_q);
					alu_b   = QUO_W'(s_q);
					state_d = ST_MULS;
				end
			end
			ST_MULS: begin
				if (alu_done) begin
					alu_req.start = 1'b1;
					alu_req.steps = STEPS_VDIV;
					alu_a   = {alu_acc, {(SHF_W-ACC_W){1'b0}}};
					alu_d   = dd_q;
					state_d = ST_VDIV;
				end
			end
			ST_VDIV: begin
				if (alu_done) begin
					alu_req.start = 1'b1;
					alu_req.mode  = ALU_SQRT;
					alu_req.steps = STEPS_SQRT;
					alu_a   = {alu_quo, {(SHF_W-QUO_W){1'b0}}};
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (alu_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// hold the word and the partial results
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= idx;
			rng_q <= in_rng;
			val_q <= vsat;
			sq_q  <= vsat * vsat;
		end
		case (state_q)
			ST_QRD: begin
				n_q    <= rn;
				s_q    <= rs;
				q_q    <= rq;
				mean_q <= '0;
				sd_q   <= '0;
				stat_q <= STAT_NODATA;
			end
			ST_MEAN: begin
				dd_q <= DVS_W'(n_q) * DVS_W'(n_q - CNT_W'(1));
				if (alu_done) begin
					mean_q <= alu_quo[FIX_W-1:0];
					stat_q <= (n_q == CNT_W'(1)) ? STAT_SINGLE : STAT_VALID;
				end
			end
			ST_SQRT: begin
				if (alu_done) begin
					sd_q <= (|alu_quo[QUO_W-1:FIX_W]) ? '1 : alu_quo[FIX_W-1:0];
				end
			end
			default: ;
		endcase
		if (load) begin
			o_stat_q <= stat_q;
			o_mean_q <= mean_q;
			o_sd_q   <= sd_q;
			o_cnt_q  <= n_q;
		end
	end

	assign rsp.valid       = ov_q;
	assign rsp.status      = o_stat_q;
	assign rsp.mean_value  = o_mean_q;
	assign rsp.stdev_value = o_sd_q;
	assign rsp.pixel_count = o_cnt_q;

endmodule
`default_nettype wire
